FILE: rtl/aligned_first_fit_allocator_assert.svh
// Assertion macros for the extent allocator.
// Each macro takes a label, an antecedent and a consequent.
`ifndef ALIGNED_FIRST_FIT_ALLOCATOR_ASSERT_SVH
`define ALIGNED_FIRST_FIT_ALLOCATOR_ASSERT_SVH
`ifndef SYNTH
`define AFA_ASSERT_IMPLY(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("allocator check failed (same cycle)");
`define AFA_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("allocator check failed (next cycle)");
`else
`define AFA_ASSERT_IMPLY(name, ante, cons)
`define AFA_ASSERT_NEXT(name, ante, cons)
`endif
`endif

FILE: rtl/afa_pkg.sv
`timescale 1ns / 1ps
package afa_pkg;

   // Fixed field widths of the stream payloads.
   localparam int FIELD_W     = 32;
   localparam int LG_W        = 5;
   localparam int COUNT_OUT_W = 7;
   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 104;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_ASCAN,
      ST_SHIFT,
      ST_WRA,
      ST_WRB,
      ST_RPASS,
      ST_STATS,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_NO_FIT    = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_ALIGN_OVF = 2'd3
   } status_type;

   typedef enum logic {
      FUNC_ALLOC   = 1'b0,
      FUNC_RELEASE = 1'b1
   } func_type;

endpackage

FILE: rtl/afa_mem.sv
`timescale 1ns / 1ps
module afa_mem #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_array [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_array[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_array[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/aligned_first_fit_allocator.sv
`timescale 1ns / 1ps
// Aligned first-fit allocator for one arena, with coalescing on release.
// Requests enter on the req_ stream: tuser is the operation (allocate or
// release), tdata carries the size, the alignment as log2 and the release
// offset. Each request gives one beat on the rsp_ stream with the status in
// tuser and the granted offset plus the free-list statistics in tdata.
// The free extents live in one memory with a registered read port, sorted
// by offset, and every operation walks it one entry per cycle.
// An allocate searches for the first fit, shifts the tail where an
// entry is added or dropped, then makes a statistics pass over the
// extents it leaves and hands the result off.
// A release takes a counting pass and a rewrite pass, then the
// statistics pass.
// One request is in work at a time; the next is taken as soon as the
// result has moved into the output register.
// After reset the block writes the single empty extent in ST_INIT
// and then holds req_tready high in idle. Writing csr_wr_data resets the
// list to one extent covering the whole arena.
// When the receiver stalls, the result beat holds and a finished operation
// waits in its last state until the output register is free.
`include "aligned_first_fit_allocator_assert.svh"
module aligned_first_fit_allocator #(
   parameter int MAX_EXTENTS = 64,
   parameter int ADDR_BITS   = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Request: tuser = func; tdata = request_bytes, alignment_log2,
   // release_offset, zero pad.
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [afa_pkg::REQ_TDATA_W-1:0]       req_tdata,
   input  logic                                  req_tuser,
   // Result: tuser = status; tdata = alloc_offset, free_bytes,
   // largest_free, extent_count, zero pad.
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [afa_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   output logic [1:0]                            rsp_tuser,
   // Arena capacity register.
   input  logic                                  csr_wr_en,
   input  logic [afa_pkg::FIELD_W-1:0]           csr_wr_data
);
   import afa_pkg::*;

   localparam int AW = ADDR_BITS;
   localparam int EW = 2 * AW;
   localparam int IW = $clog2(MAX_EXTENTS);
   localparam int CW = $clog2(MAX_EXTENTS + 1);
   localparam int MW = $clog2(MAX_EXTENTS + 2);
   localparam int SW = ((AW > FIELD_W) ? AW : FIELD_W) + 1;

   // Control state.
   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    idx_ff, idx_in;
   logic             vld_ff, vld_in;
   logic [IW-1:0]    pidx_ff, pidx_in;
   logic [CW-1:0]    rem_ff, rem_in;
   logic             up_ff, up_in;
   logic             two_ff, two_in;
   logic [MW-1:0]    m_ff, m_in;
   logic             placed_ff, placed_in;
   logic             commit_ff, commit_in;
   logic             acc_vld_ff, acc_vld_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Datapath registers.
   logic [AW-1:0]    acc_s_ff, acc_s_in;
   logic [AW-1:0]    acc_l_ff, acc_l_in;
   logic [IW-1:0]    ai_ff, ai_in;
   logic [AW-1:0]    a_off_ff, a_off_in;
   logic [AW-1:0]    a_pre_ff, a_pre_in;
   logic [AW-1:0]    a_suf_ff, a_suf_in;
   logic [AW-1:0]    a_sst_ff, a_sst_in;
   logic [AW-1:0]    granted_ff, granted_in;
   logic [AW-1:0]    tot_ff, tot_in;
   logic [AW-1:0]    big_ff, big_in;
   status_type       status_ff, status_in;

   // Request payload.
   func_type         func_ff;
   logic [AW-1:0]    bytes_ff;
   logic [LG_W-1:0]  lg_ff;
   logic [AW-1:0]    roff_ff;

   // Result register.
   status_type       rsp_status_ff;
   logic [AW-1:0]    rsp_off_ff;
   logic [AW-1:0]    rsp_free_ff;
   logic [AW-1:0]    rsp_big_ff;
   logic [CW-1:0]    rsp_count_ff;

   // Memory port.
   logic             mem_we;
   logic [IW-1:0]    mem_waddr;
   logic [EW-1:0]    mem_wdata;
   logic             mem_re;
   logic [IW-1:0]    mem_raddr;
   logic [EW-1:0]    mem_rdata;
   logic [AW-1:0]    rd_s;
   logic [AW-1:0]    rd_l;

   logic             req_beat;

   afa_mem #(
      .DEPTH (MAX_EXTENTS),
      .WIDTH (EW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign rd_s     = mem_rdata[EW-1:AW];
   assign rd_l     = mem_rdata[AW-1:0];
   assign req_beat = req_tvalid && req_tready;

   // Fit test of the extent on the read port against the pending allocate.
   logic [SW-1:0]    am1;
   logic [SW-1:0]    asum;
   logic             a_ovf;
   logic [AW-1:0]    a_al;
   logic [AW-1:0]    a_pre;
   logic             a_fit;
   logic [AW-1:0]    a_suf;
   logic [AW-1:0]    a_sst;

   always_comb begin
      am1   = SW'((64'd1 << lg_ff) - 64'd1);
      asum  = SW'(rd_s) + am1;
      a_ovf = (asum[SW-1:AW] != '0);
      a_al  = AW'(asum & ~am1);
      a_pre = a_al - rd_s;
      a_fit = (a_pre <= rd_l) && (bytes_ff <= rd_l - a_pre);
      a_suf = rd_l - a_pre - bytes_ff;
      a_sst = a_al + bytes_ff;
   end

   // Stream item for the release pass and its merge with the accumulator.
   logic             r_gt;
   logic [AW-1:0]    it_s;
   logic [AW-1:0]    it_l;
   logic             it_join;
   logic [AW:0]      join_sum;
   logic [AW:0]      tot_sum;

   always_comb begin
      r_gt     = rd_s > roff_ff;
      if (vld_ff && (placed_ff || !r_gt)) begin
         it_s = rd_s;
         it_l = rd_l;
      end else begin
         it_s = roff_ff;
         it_l = bytes_ff;
      end
      it_join  = acc_vld_ff &&
                 (({1'b0, acc_s_ff} + {1'b0, acc_l_ff}) == {1'b0, it_s});
      join_sum = {1'b0, acc_l_ff} + {1'b0, it_l};
      tot_sum  = {1'b0, tot_ff} + {1'b0, rd_l};
   end

   // Sequencer: next state, memory accesses and datapath updates.
   always_comb begin
      logic          have_item;
      logic          consume;
      logic          more;
      logic [MW-1:0] m_fin;

      have_item    = 1'b0;
      consume      = 1'b0;
      more         = idx_ff < count_ff;
      m_fin        = m_ff + MW'(1);

      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      vld_in       = vld_ff;
      pidx_in      = pidx_ff;
      rem_in       = rem_ff;
      up_in        = up_ff;
      two_in       = two_ff;
      m_in         = m_ff;
      placed_in    = placed_ff;
      commit_in    = commit_ff;
      acc_vld_in   = acc_vld_ff;
      acc_s_in     = acc_s_ff;
      acc_l_in     = acc_l_ff;
      ai_in        = ai_ff;
      a_off_in     = a_off_ff;
      a_pre_in     = a_pre_ff;
      a_suf_in     = a_suf_ff;
      a_sst_in     = a_sst_ff;
      granted_in   = granted_ff;
      tot_in       = tot_ff;
      big_in       = big_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = '0;
      mem_re       = 1'b0;
      mem_raddr    = idx_ff[IW-1:0];

      unique case (state_ff)
         ST_INIT: begin
            // Empty extent at offset zero.
            mem_we   = 1'b1;
            count_in = CW'(1);
            state_in = ST_IDLE;
         end

         ST_IDLE: begin
            if (req_beat) begin
               idx_in     = '0;
               vld_in     = 1'b0;
               m_in       = '0;
               placed_in  = 1'b0;
               commit_in  = 1'b0;
               acc_vld_in = 1'b0;
               status_in  = STAT_OK;
               granted_in = '0;
               state_in   = (func_type'(req_tuser) == FUNC_RELEASE) ? ST_RPASS : ST_ASCAN;
            end
         end

         ST_ASCAN: begin
            // First-fit search, one extent per cycle.
            if (vld_ff && a_ovf) begin
               status_in = STAT_ALIGN_OVF;
               idx_in    = '0;
               vld_in    = 1'b0;
               tot_in    = '0;
               big_in    = '0;
               state_in  = ST_STATS;
            end else if (vld_ff && a_fit) begin
               ai_in    = pidx_ff;
               a_off_in = rd_s;
               a_pre_in = a_pre;
               a_suf_in = a_suf;
               a_sst_in = a_sst;
               two_in   = (a_pre != '0) && (a_suf != '0);
               rem_in   = CW'(count_ff - CW'(1) - CW'(pidx_ff));
               vld_in   = 1'b0;
               idx_in   = '0;
               tot_in   = '0;
               big_in   = '0;
               if ((a_pre != '0) && (a_suf != '0) && (count_ff == CW'(MAX_EXTENTS))) begin
                  status_in = STAT_FULL;
                  state_in  = ST_STATS;
               end else begin
                  granted_in = a_al;
                  if ((a_pre != '0) && (a_suf != '0)) begin
                     // Both remnants: open a slot above the extent.
                     up_in    = 1'b1;
                     count_in = count_ff + CW'(1);
                     if (count_ff - CW'(1) != CW'(pidx_ff)) begin
                        idx_in   = count_ff - CW'(1);
                        state_in = ST_SHIFT;
                     end else begin
                        state_in = ST_WRA;
                     end
                  end else if ((a_pre != '0) || (a_suf != '0)) begin
                     state_in = ST_WRA;
                  end else begin
                     // Extent used up: close the gap.
                     up_in    = 1'b0;
                     count_in = count_ff - CW'(1);
                     if (count_ff - CW'(1) != CW'(pidx_ff)) begin
                        idx_in   = CW'(pidx_ff) + CW'(1);
                        state_in = ST_SHIFT;
                     end else begin
                        state_in = ST_STATS;
                     end
                  end
               end
            end else if (!vld_ff && !more) begin
               status_in = STAT_NO_FIT;
               idx_in    = '0;
               tot_in    = '0;
               big_in    = '0;
               state_in  = ST_STATS;
            end else if (more) begin
               mem_re  = 1'b1;
               vld_in  = 1'b1;
               pidx_in = idx_ff[IW-1:0];
               idx_in  = idx_ff + CW'(1);
            end else begin
               vld_in = 1'b0;
            end
         end

         ST_SHIFT: begin
            // Move the tail by one entry, read and write pipelined.
            if (vld_ff) begin
               mem_we    = 1'b1;
               mem_waddr = up_ff ? (pidx_ff + IW'(1)) : (pidx_ff - IW'(1));
               mem_wdata = mem_rdata;
            end
            if (rem_ff != '0) begin
               mem_re  = 1'b1;
               vld_in  = 1'b1;
               pidx_in = idx_ff[IW-1:0];
               idx_in  = up_ff ? (idx_ff - CW'(1)) : (idx_ff + CW'(1));
               rem_in  = rem_ff - CW'(1);
            end else begin
               vld_in = 1'b0;
               idx_in = '0;
               tot_in = '0;
               big_in = '0;
               state_in = up_ff ? ST_WRA : ST_STATS;
            end
         end

         ST_WRA: begin
            mem_we    = 1'b1;
            mem_waddr = ai_ff;
            mem_wdata = (a_pre_ff != '0) ? {a_off_ff, a_pre_ff} : {a_sst_ff, a_suf_ff};
            idx_in    = '0;
            vld_in    = 1'b0;
            tot_in    = '0;
            big_in    = '0;
            state_in  = two_ff ? ST_WRB : ST_STATS;
         end

         ST_WRB: begin
            mem_we    = 1'b1;
            mem_waddr = ai_ff + IW'(1);
            mem_wdata = {a_sst_ff, a_suf_ff};
            state_in  = ST_STATS;
         end

         ST_RPASS: begin
            // Sorted insert and coalescing as one stream; the first pass
            // only counts, the second writes back in place.
            if (vld_ff) begin
               have_item = 1'b1;
               if (!placed_ff && r_gt) begin
                  placed_in = 1'b1;
               end else begin
                  consume = 1'b1;
               end
            end else if (!more) begin
               if (!placed_ff) begin
                  have_item = 1'b1;
                  placed_in = 1'b1;
               end else begin
                  // End of stream: flush the accumulator.
                  if (commit_ff) begin
                     mem_we    = 1'b1;
                     mem_waddr = m_ff[IW-1:0];
                     mem_wdata = {acc_s_ff, acc_l_ff};
                  end
                  idx_in     = '0;
                  vld_in     = 1'b0;
                  m_in       = '0;
                  placed_in  = 1'b0;
                  acc_vld_in = 1'b0;
                  tot_in     = '0;
                  big_in     = '0;
                  if (commit_ff) begin
                     count_in = CW'(m_fin);
                     state_in = ST_STATS;
                  end else if (m_fin > MW'(MAX_EXTENTS)) begin
                     status_in = STAT_FULL;
                     state_in  = ST_STATS;
                  end else begin
                     commit_in = 1'b1;
                  end
               end
            end else begin
               consume = 1'b1;
            end

            if (have_item) begin
               if (it_join) begin
                  acc_l_in = join_sum[AW] ? {AW{1'b1}} : join_sum[AW-1:0];
               end else begin
                  if (acc_vld_ff) begin
                     if (commit_ff) begin
                        mem_we    = 1'b1;
                        mem_waddr = m_ff[IW-1:0];
                        mem_wdata = {acc_s_ff, acc_l_ff};
                     end
                     m_in = m_fin;
                  end
                  acc_vld_in = 1'b1;
                  acc_s_in   = it_s;
                  acc_l_in   = it_l;
               end
            end

            if (consume) begin
               if (more) begin
                  mem_re  = 1'b1;
                  vld_in  = 1'b1;
                  pidx_in = idx_ff[IW-1:0];
                  idx_in  = idx_ff + CW'(1);
               end else begin
                  vld_in = 1'b0;
               end
            end
         end

         ST_STATS: begin
            // Saturating total and running maximum over the list.
            if (vld_ff) begin
               tot_in = tot_sum[AW] ? {AW{1'b1}} : tot_sum[AW-1:0];
               if (rd_l > big_ff) begin
                  big_in = rd_l;
               end
            end
            if (more) begin
               mem_re  = 1'b1;
               vld_in  = 1'b1;
               pidx_in = idx_ff[IW-1:0];
               idx_in  = idx_ff + CW'(1);
            end else begin
               vld_in = 1'b0;
               if (!vld_ff) begin
                  state_in = ST_DONE;
               end
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Capacity write rebuilds the list as one extent.
      if (csr_wr_en) begin
         mem_we    = 1'b1;
         mem_waddr = '0;
         mem_wdata = {{AW{1'b0}}, AW'(csr_wr_data)};
         count_in  = CW'(1);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         count_ff     <= CW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Sequencer and datapath registers.
   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      vld_ff     <= vld_in;
      pidx_ff    <= pidx_in;
      rem_ff     <= rem_in;
      up_ff      <= up_in;
      two_ff     <= two_in;
      m_ff       <= m_in;
      placed_ff  <= placed_in;
      commit_ff  <= commit_in;
      acc_vld_ff <= acc_vld_in;
      acc_s_ff   <= acc_s_in;
      acc_l_ff   <= acc_l_in;
      ai_ff      <= ai_in;
      a_off_ff   <= a_off_in;
      a_pre_ff   <= a_pre_in;
      a_suf_ff   <= a_suf_in;
      a_sst_ff   <= a_sst_in;
      granted_ff <= granted_in;
      tot_ff     <= tot_in;
      big_ff     <= big_in;
      status_ff  <= status_in;
   end

   // Request payload capture.
   always_ff @(posedge clock) begin
      if (req_beat) begin
         func_ff  <= func_type'(req_tuser);
         bytes_ff <= AW'(req_tdata[FIELD_W-1:0]);
         lg_ff    <= req_tdata[FIELD_W+LG_W-1:FIELD_W];
         roff_ff  <= AW'(req_tdata[2*FIELD_W+LG_W-1:FIELD_W+LG_W]);
      end
   end

   // Result register, loaded when the operation finishes.
   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_tready)) begin
         rsp_status_ff <= status_ff;
         rsp_off_ff    <= (status_ff == STAT_OK && func_ff == FUNC_ALLOC) ? granted_ff : '0;
         rsp_free_ff   <= tot_ff;
         rsp_big_ff    <= big_ff;
         rsp_count_ff  <= count_ff;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - 3*FIELD_W - COUNT_OUT_W){1'b0}},
                        COUNT_OUT_W'(rsp_count_ff),
                        FIELD_W'(rsp_big_ff),
                        FIELD_W'(rsp_free_ff),
                        FIELD_W'(rsp_off_ff)};

   // Checks.
   `AFA_ASSERT_IMPLY(a_count_max, 1'b1, count_ff <= CW'(MAX_EXTENTS))
   `AFA_ASSERT_IMPLY(a_write_behind, state_ff == ST_RPASS && mem_we && vld_ff, mem_waddr <= pidx_ff)
   `AFA_ASSERT_IMPLY(a_zero_offset, rsp_tvalid && rsp_tuser != STAT_OK, rsp_tdata[31:0] == 32'd0)
   `AFA_ASSERT_NEXT(a_result_loaded, state_ff == ST_DONE && (!rsp_valid_ff || rsp_tready), rsp_tvalid)

endmodule
